>>> hdl/tlr_pkg.sv
// tlr_pkg: shared types and constants for the checked line receiver
// operation and event codes, character constants and the result record
// no dependencies
package tlr_pkg;

  localparam int unsigned CHAR_W = 7;

  // transaction operation codes (code 3 is unused and does nothing)
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  // per-transaction event codes
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_STORED    = 3'd1,
    EV_IGNORED   = 3'd2,
    EV_ACCEPTED  = 3'd3,
    EV_BAD_SUM   = 3'd4,
    EV_TOO_SHORT = 3'd5,
    EV_DISCARDED = 3'd6,
    EV_ERROR     = 3'd7
  } event_e;

  // active buffer selection codes (0 and 3 both mean none)
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_FIRST  = 2'd1;
  localparam logic [1:0] ACT_SECOND = 2'd2;

  // character constants
  localparam logic [CHAR_W-1:0] CHAR_CR   = 7'h0d;
  localparam logic [CHAR_W-1:0] CHAR_MIN  = 7'd32;
  localparam logic [CHAR_W-1:0] SUM_BIAS  = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h00;
  localparam int unsigned       MIN_LINE  = 2;

  // result record carried through the output pipeline
  typedef struct packed {
    event_e            ev;
    logic              done_buf;
    logic [6:0]        len;
    logic              first_ready;
    logic              second_ready;
  } res_t;

endpackage

>>> hdl/tlr_line_store.sv
// tlr_line_store: one line buffer, a synchronous memory of characters
// one write port, one read port with a registered read
// depends on tlr_pkg for the character width
module tlr_line_store
  import tlr_pkg::*;
#(
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem_q [Depth];
  logic [CHAR_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its value between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/teleinfo_checked_line_receiver_top.sv
// teleinfo_checked_line_receiver_top: line assembly into two line buffers
// with checksum check, release and character readout
// depends on tlr_pkg and tlr_line_store
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------
//  input   | in        | in_valid_i / in_stall_o  | operation, rx_byte, rx_error,
//          |           |                          | buffer_select, read_index
//  output  | out       | out_valid_o / out_stall_i| event_res, completed_buffer,
//          |           |                          | line_length, read_data, ready flags
//
// One transaction per cycle sustained while the output is not stalled.
// The line state updates at the accept edge; the buffer memory read registers at
// that edge too, so the result passes one stage then the output register.
// Reset clears line state and flags; buffer contents stay undefined until written.
// A stalled output fills the stage behind it, then the input stalls.
module teleinfo_checked_line_receiver_top
  import tlr_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   operation_i,
  input  logic [7:0]   rx_byte_i,
  input  logic         rx_error_i,
  input  logic         buffer_select_i,
  input  logic [6:0]   read_index_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [2:0]   event_res_o,
  output logic         completed_buffer_o,
  output logic [6:0]   line_length_o,
  output logic [6:0]   read_data_o,
  output logic         first_ready_o,
  output logic         second_ready_o
);

  localparam int unsigned AW  = $clog2(LINE_DEPTH);
  localparam int unsigned WPW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned LW  = (WPW > 7) ? WPW : 7;

  // line state
  logic [WPW-1:0]    wp_q, wp_d;
  logic [1:0]        act_q, act_d;
  logic [7:0]        sum_q, sum_d;
  logic [CHAR_W-1:0] last_q, last_d;
  logic [1:0]        ready_q, ready_d;

  // pipeline
  logic              s1_valid_q;
  res_t              s1_res_q;
  logic              s1_rd_q;
  logic              s1_sel_q;
  logic              out_valid_q;
  res_t              out_res_q;
  logic [CHAR_W-1:0] out_data_q;

  logic              acc;
  logic              s1_adv;
  res_t              res;
  logic              rd_en;
  logic              rd_ok;
  logic [CHAR_W-1:0] ch;
  logic [7:0]        sum_diff;
  logic [CHAR_W-1:0] expect_chr;
  logic [WPW-1:0]    wp_m2;
  logic [LW-1:0]     len_w;
  logic [LW-1:0]     ridx;
  logic              we_a, we_b;
  logic [AW-1:0]     waddr;
  logic [CHAR_W-1:0] wdata;
  logic [CHAR_W-1:0] rdata_a, rdata_b;

  // handshake
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign acc        = in_valid_i && !in_stall_o;

  // character, checksum and address helpers
  assign ch         = rx_byte_i[CHAR_W-1:0];
  assign sum_diff   = sum_q - 8'(last_q);
  assign expect_chr = {1'b0, sum_diff[5:0]} + SUM_BIAS;
  assign wp_m2      = wp_q - WPW'(MIN_LINE);
  assign len_w      = LW'(wp_q) - LW'(MIN_LINE);
  assign ridx       = LW'(read_index_i);
  assign rd_ok      = ridx < LW'(LINE_DEPTH);

  // next line state, memory write and result for one transaction
  always_comb begin
    wp_d    = wp_q;
    act_d   = act_q;
    sum_d   = sum_q;
    last_d  = last_q;
    ready_d = ready_q;
    we_a    = 1'b0;
    we_b    = 1'b0;
    waddr   = wp_q[AW-1:0];
    wdata   = ch;
    rd_en   = 1'b0;
    res     = '{ev: EV_NONE, done_buf: 1'b0, len: 7'd0,
                first_ready: 1'b0, second_ready: 1'b0};
    unique case (operation_i)
      OP_BYTE: begin
        if (rx_error_i) begin
          wp_d   = WPW'(LINE_DEPTH);
          res.ev = EV_ERROR;
        end else if (wp_q >= WPW'(LINE_DEPTH)) begin
          // discarding until carriage return, which picks a free buffer (first preferred) if any
          if (ch == CHAR_CR) begin
            wp_d  = '0;
            sum_d = '0;
            if (!ready_q[0]) begin
              act_d = ACT_FIRST;
            end else if (!ready_q[1]) begin
              act_d = ACT_SECOND;
            end
          end
          res.ev = EV_DISCARDED;
        end else if (act_q != ACT_FIRST && act_q != ACT_SECOND) begin
          wp_d   = WPW'(LINE_DEPTH);
          res.ev = EV_DISCARDED;
        end else if (ch == CHAR_CR) begin
          wp_d  = '0;
          sum_d = '0;
          if (wp_q < WPW'(MIN_LINE)) begin
            res.ev = EV_TOO_SHORT;
          end else if (expect_chr != last_q) begin
            res.ev = EV_BAD_SUM;
          end else begin
            // terminate the line over the separator position and swap buffers if the other is free
            waddr   = wp_m2[AW-1:0];
            wdata   = CHAR_ZERO;
            res.len = len_w[6:0];
            res.ev  = EV_ACCEPTED;
            if (act_q == ACT_SECOND) begin
              we_b         = 1'b1;
              res.done_buf = 1'b1;
              ready_d[1]   = 1'b1;
              act_d        = ready_q[0] ? ACT_NONE : ACT_FIRST;
            end else begin
              we_a         = 1'b1;
              ready_d[0]   = 1'b1;
              act_d        = ready_q[1] ? ACT_NONE : ACT_SECOND;
            end
          end
        end else if (ch >= CHAR_MIN) begin
          we_a   = (act_q == ACT_FIRST);
          we_b   = (act_q == ACT_SECOND);
          last_d = ch;
          sum_d  = sum_q + 8'(ch);
          wp_d   = wp_q + WPW'(1);
          res.ev = EV_STORED;
        end else begin
          res.ev = EV_IGNORED;
        end
      end
      OP_RELEASE: begin
        ready_d[buffer_select_i] = 1'b0;
      end
      OP_READ: begin
        rd_en = rd_ok;
      end
      default: begin
      end
    endcase
    res.first_ready  = ready_d[0];
    res.second_ready = ready_d[1];
  end

  // line buffers
  tlr_line_store #(.Depth(LINE_DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (acc && we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (acc && rd_en && !buffer_select_i),
    .raddr_i (ridx[AW-1:0]),
    .rdata_o (rdata_a)
  );

  tlr_line_store #(.Depth(LINE_DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (acc && we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (acc && rd_en && buffer_select_i),
    .raddr_i (ridx[AW-1:0]),
    .rdata_o (rdata_b)
  );

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      act_q   <= ACT_FIRST;
      sum_q   <= '0;
      last_q  <= '0;
      ready_q <= '0;
    end else if (acc) begin
      wp_q    <= wp_d;
      act_q   <= act_d;
      sum_q   <= sum_d;
      last_q  <= last_d;
      ready_q <= ready_d;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_res_q <= res;
      s1_rd_q  <= rd_en;
      s1_sel_q <= buffer_select_i;
    end
    if (s1_adv && s1_valid_q) begin
      out_res_q  <= s1_res_q;
      out_data_q <= !s1_rd_q ? CHAR_ZERO : (s1_sel_q ? rdata_b : rdata_a);
    end
  end

  // outputs
  assign out_valid_o        = out_valid_q;
  assign event_res_o        = out_res_q.ev;
  assign completed_buffer_o = out_res_q.done_buf;
  assign line_length_o      = out_res_q.len;
  assign read_data_o        = out_data_q;
  assign first_ready_o      = out_res_q.first_ready;
  assign second_ready_o     = out_res_q.second_ready;

  // the active buffer never holds an unreleased line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q == ACT_FIRST) |-> !ready_q[0])
    else $error("active buffer is the first one while it is marked ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q == ACT_SECOND) |-> !ready_q[1])
    else $error("active buffer is the second one while it is marked ready");

  // write position never passes the discard mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= WPW'(LINE_DEPTH))
    else $error("write position beyond buffer depth");

  // an accepted line reports its buffer as ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.ev == EV_ACCEPTED) |->
      (out_res_q.done_buf ? out_res_q.second_ready : out_res_q.first_ready))
    else $error("accepted line without its ready flag");

  // a full stage behind a stalled output stops the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while the pipeline is full");

endmodule

>>> tb/testbench.sv
// testbench for teleinfo_checked_line_receiver_top: line assembly, checksum,
// release and readout checked against a local predictor of the receiver
// depends on tlr_pkg and the receiver rtl
module testbench;
  import tlr_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 265;

  // one input transaction
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
    logic       err;
    logic       sel;
    logic [6:0] idx;
  } rx_item_t;

  // one result transaction
  typedef struct packed {
    event_e     ev;
    logic       done_buf;
    logic [6:0] len;
    logic [6:0] data;
    logic       fr;
    logic       sr;
  } line_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] operation_i = 2'd0;
  logic [7:0] rx_byte_i = 8'd0;
  logic       rx_error_i = 1'b0;
  logic       buffer_select_i = 1'b0;
  logic [6:0] read_index_i = 7'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] event_res_o;
  logic       completed_buffer_o;
  logic [6:0] line_length_o;
  logic [6:0] read_data_o;
  logic       first_ready_o;
  logic       second_ready_o;

  teleinfo_checked_line_receiver_top #(.LINE_DEPTH(DEPTH)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .rx_byte_i          (rx_byte_i),
    .rx_error_i         (rx_error_i),
    .buffer_select_i    (buffer_select_i),
    .read_index_i       (read_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .event_res_o        (event_res_o),
    .completed_buffer_o (completed_buffer_o),
    .line_length_o      (line_length_o),
    .read_data_o        (read_data_o),
    .first_ready_o      (first_ready_o),
    .second_ready_o     (second_ready_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver state, two copies: [0] follows generation, [1] follows accepted transactions
  logic [6:0] line_mem   [2][2][DEPTH];
  int         filled_to  [2][2];
  logic [7:0] wr_pos     [2];
  logic [1:0] act_sel    [2];
  logic [7:0] char_sum   [2];
  logic [6:0] last_char  [2];
  logic [1:0] ready_bits [2];

  rx_item_t     pending_q [$];
  line_result_t expected_q [$];
  int gap_pct = 23;
  int stall_pct = 51;
  int mismatches = 0;
  int accepted = 0;
  int phase_items = 0;
  int idle_cycles = 0;
  int ev_count [8];
  bit running = 1'b0;

  function automatic void clear_receiver_state();
    for (int v = 0; v < 2; v++) begin
      wr_pos[v] = 8'd0;
      act_sel[v] = ACT_FIRST;
      char_sum[v] = 8'd0;
      last_char[v] = 7'd0;
      ready_bits[v] = 2'b00;
      for (int b = 0; b < 2; b++) begin
        filled_to[v][b] = 0;
        for (int i = 0; i < DEPTH; i++) line_mem[v][b][i] = 7'd0;
      end
    end
    for (int e = 0; e < 8; e++) ev_count[e] = 0;
  endfunction

  // advance one copy of the receiver by one transaction and give its result
  function automatic line_result_t receiver_step(input int v, input rx_item_t it);
    line_result_t r;
    logic [6:0]   c;
    logic [7:0]   diff;
    logic [7:0]   chk;
    logic [7:0]   len_full;
    int           b;
    r = '0;
    r.ev = EV_NONE;
    c = it.rx[6:0];
    if (it.op == OP_BYTE) begin
      if (it.err) begin
        wr_pos[v] = 8'(DEPTH);
        r.ev = EV_ERROR;
      end else if (wr_pos[v] >= DEPTH) begin
        // discarding: carriage return resyncs onto a free buffer, first preferred
        if (c == CHAR_CR) begin
          wr_pos[v] = 8'd0;
          char_sum[v] = 8'd0;
          if (!ready_bits[v][0]) act_sel[v] = ACT_FIRST;
          else if (!ready_bits[v][1]) act_sel[v] = ACT_SECOND;
        end
        r.ev = EV_DISCARDED;
      end else if (act_sel[v] != ACT_FIRST && act_sel[v] != ACT_SECOND) begin
        wr_pos[v] = 8'(DEPTH);
        r.ev = EV_DISCARDED;
      end else begin
        b = (act_sel[v] == ACT_SECOND) ? 1 : 0;
        if (c == CHAR_CR) begin
          diff = char_sum[v] - {1'b0, last_char[v]};
          chk = {2'b00, diff[5:0]} + {1'b0, SUM_BIAS};
          if (wr_pos[v] < MIN_LINE) begin
            r.ev = EV_TOO_SHORT;
          end else if (chk != {1'b0, last_char[v]}) begin
            r.ev = EV_BAD_SUM;
          end else begin
            // good line: terminate ahead of separator and checksum, flip buffers if the other is free
            len_full = wr_pos[v] - 8'd2;
            line_mem[v][b][len_full] = CHAR_ZERO;
            r.len = len_full[6:0];
            r.done_buf = b[0];
            r.ev = EV_ACCEPTED;
            ready_bits[v][b] = 1'b1;
            if (ready_bits[v][1-b]) act_sel[v] = ACT_NONE;
            else act_sel[v] = (b == 1) ? ACT_FIRST : ACT_SECOND;
          end
          wr_pos[v] = 8'd0;
          char_sum[v] = 8'd0;
        end else if (c >= CHAR_MIN) begin
          line_mem[v][b][wr_pos[v]] = c;
          if (int'(wr_pos[v]) + 1 > filled_to[v][b])
            filled_to[v][b] = int'(wr_pos[v]) + 1;
          last_char[v] = c;
          char_sum[v] = char_sum[v] + {1'b0, c};
          wr_pos[v] = wr_pos[v] + 8'd1;
          r.ev = EV_STORED;
        end else begin
          r.ev = EV_IGNORED;
        end
      end
    end else if (it.op == OP_RELEASE) begin
      ready_bits[v][it.sel] = 1'b0;
    end else if (it.op == OP_READ) begin
      if (it.idx < DEPTH) r.data = line_mem[v][it.sel][it.idx];
    end
    r.fr = ready_bits[v][0];
    r.sr = ready_bits[v][1];
    return r;
  endfunction

  // fields that an operation ignores still toggle
  function automatic rx_item_t random_item();
    rx_item_t it;
    it.op = 2'($urandom_range(0, 3));
    it.rx = 8'($urandom_range(0, 255));
    it.err = ($urandom_range(0, 3) == 0);
    it.sel = 1'($urandom_range(0, 1));
    it.idx = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic void push_item(input rx_item_t it);
    line_result_t r;
    r = receiver_step(0, it);
    pending_q.push_back(it);
    if (it.op != OP_UNUSED && r.ev != EV_IGNORED) phase_items++;
  endfunction

  function automatic void push_raw(input logic [7:0] raw, input logic err);
    rx_item_t it;
    it = random_item();
    it.op = OP_BYTE;
    it.rx = raw;
    it.err = err;
    push_item(it);
  endfunction

  function automatic void push_byte(input logic [6:0] c, input logic err);
    push_raw({1'($urandom_range(0, 1)), c}, err);
  endfunction

  function automatic void push_op(input logic [1:0] op, input logic sel,
                                  input logic [6:0] idx);
    rx_item_t it;
    it = random_item();
    it.op = op;
    it.sel = sel;
    it.idx = idx;
    push_item(it);
  endfunction

  // control character other than carriage return
  function automatic logic [6:0] ctl_char();
    int c;
    c = $urandom_range(0, 30);
    if (c >= 13) c++;
    return 7'(c);
  endfunction

  // payload, separator, checksum, carriage return, with occasional noise inside
  function automatic void push_line(input int n, input bit good);
    logic [7:0] sum;
    logic [6:0] c;
    logic [6:0] cs;
    bit         spoil;
    sum = 8'd0;
    spoil = ($urandom_range(0, 99) < 3);
    if ($urandom_range(0, 1) == 1) push_byte(ctl_char(), 1'b0);
    for (int i = 0; i <= n; i++) begin
      if (i < n) c = 7'($urandom_range(32, 127));
      else if ($urandom_range(0, 3) == 0) c = 7'($urandom_range(32, 127));
      else c = 7'h20;
      if ($urandom_range(0, 99) < 5) push_byte(ctl_char(), 1'b0);
      if (spoil && i == n / 2) push_byte(7'($urandom_range(0, 127)), 1'b1);
      push_byte(c, 1'b0);
      sum = sum + {1'b0, c};
    end
    cs = {1'b0, sum[5:0]} + SUM_BIAS;
    if (!good) cs = cs ^ 7'($urandom_range(1, 31));
    push_byte(cs, 1'b0);
    push_byte(CHAR_CR, 1'b0);
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
  endtask

  // driver: present pending transactions, predict each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    rx_item_t     nxt;
    rx_item_t     acc;
    line_result_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        acc.op = operation_i;
        acc.rx = rx_byte_i;
        acc.err = rx_error_i;
        acc.sel = buffer_select_i;
        acc.idx = read_index_i;
        r = receiver_step(1, acc);
        expected_q.push_back(r);
        ev_count[int'(r.ev)]++;
        accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = pending_q.pop_front();
          operation_i <= nxt.op;
          rx_byte_i <= nxt.rx;
          rx_error_i <= nxt.err;
          buffer_select_i <= nxt.sel;
          read_index_i <= nxt.idx;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result with none expected: %s%0d %s%0d %s%0d",
                     "ev=", event_res_o, "buf=", completed_buffer_o,
                     "len=", line_length_o);
        end else begin
          e = expected_q.pop_front();
          if (event_res_o !== e.ev || completed_buffer_o !== e.done_buf ||
              line_length_o !== e.len || read_data_o !== e.data ||
              first_ready_o !== e.fr || second_ready_o !== e.sr) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: exp ev=%0d buf=%0d len=%0d data=%0d rdy=%0d%0d",
                       e.ev, e.done_buf, e.len, e.data, e.sr, e.fr);
              $display("       got ev=%0d buf=%0d len=%0d data=%0d rdy=%0d%0d",
                       event_res_o, completed_buffer_o, line_length_o, read_data_o,
                       second_ready_o, first_ready_o);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog on transactions while stimulus is in flight
  always @(posedge clk_i) begin
    if (running && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("teleinfo_checked_line_receiver_top verification failed");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    int         r;
    int         n;
    logic       sel;
    rx_item_t   it;
    clear_receiver_state();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    running = 1'b1;

    // directed: unused op, short lines, error resync, extremes, both buffers busy
    push_op(OP_UNUSED, 1'b1, 7'h7f);
    push_byte(CHAR_CR, 1'b0);
    push_byte(7'h41, 1'b0);
    push_byte(CHAR_CR, 1'b0);
    push_byte(7'h55, 1'b1);
    push_byte(7'h41, 1'b0);
    push_byte(CHAR_CR, 1'b0);
    push_raw(8'hff, 1'b0);
    push_raw(8'h20, 1'b0);
    push_raw(8'h3f, 1'b0);
    push_raw(8'h0d, 1'b0);
    push_raw(8'h00, 1'b0);
    push_op(OP_READ, 1'b0, 7'd0);
    push_op(OP_READ, 1'b0, 7'd2);
    push_byte(7'h20, 1'b0);
    push_byte(7'h41, 1'b0);
    push_byte(CHAR_CR, 1'b0);
    push_raw(8'ha0, 1'b0);
    push_raw(8'hc0, 1'b0);
    push_raw(8'h8d, 1'b0);
    push_byte(7'h5a, 1'b0);
    push_byte(CHAR_CR, 1'b0);
    push_op(OP_RELEASE, 1'b0, 7'd0);
    push_op(OP_RELEASE, 1'b0, 7'd0);
    push_byte(7'h5a, 1'b0);
    push_byte(CHAR_CR, 1'b0);
    push_op(OP_READ, 1'b0, 7'd1);
    push_op(OP_READ, 1'b1, 7'd0);
    push_op(OP_RELEASE, 1'b1, 7'd0);

    // random phases: receiver stalls most, then sender idles most, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 23 : (ph == 1) ? 51 : 0;
      stall_pct = (ph == 0) ? 51 : (ph == 1) ? 23 : 0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          r = $urandom_range(0, 99);
          if (r < 3) n = 125;
          else if (r < 5) n = $urandom_range(126, 130);
          else n = $urandom_range(0, 12);
          push_line(n, $urandom_range(0, 99) < 85);
        end else if (r < 75) begin
          sel = 1'($urandom_range(0, 1));
          if (filled_to[0][sel] == 0) sel = !sel;
          if (filled_to[0][sel] != 0)
            repeat ($urandom_range(1, 3))
              push_op(OP_READ, sel, 7'($urandom_range(0, filled_to[0][sel] - 1)));
        end else if (r < 90) begin
          sel = 1'($urandom_range(0, 1));
          if (!ready_bits[0][sel] && $urandom_range(0, 99) < 70) sel = !sel;
          push_op(OP_RELEASE, sel, 7'($urandom_range(0, 127)));
        end else begin
          // noise: any operation with random fields, reads kept on written entries
          it = random_item();
          if (it.op == OP_READ) begin
            if (filled_to[0][it.sel] == 0) it.op = OP_BYTE;
            else it.idx = 7'($urandom_range(0, filled_to[0][it.sel] - 1));
          end
          push_item(it);
        end
      end
      // hold the sender until every result of this phase is back
      wait_drained();
    end

    running = 1'b0;
    repeat (8) @(negedge clk_i);
    $display("run: %0d transactions, %0d lines accepted, %0d bad checksum, %0d too short",
             accepted, ev_count[EV_ACCEPTED], ev_count[EV_BAD_SUM], ev_count[EV_TOO_SHORT]);
    $display("     %0d discarded, %0d receive errors, %0d mismatches",
             ev_count[EV_DISCARDED], ev_count[EV_ERROR], mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("teleinfo_checked_line_receiver_top verification clean");
    end else begin
      $display("teleinfo_checked_line_receiver_top verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tlr_pkg.sv
hdl/tlr_line_store.sv
hdl/teleinfo_checked_line_receiver_top.sv
tb/testbench.sv
